// ===== hdl/rsda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation speed deviation alarm package
// Widths, reset values, request and register codes, sequencer states and the
// status group of the shared serial divider.
// ----------------------------------------------------------------------------
package rsda_pkg;

    localparam int DATA_W    = 32;
    localparam int THR_W     = 7;
    localparam int RPM_W     = 33;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = DATA_W + 8;

    localparam longint unsigned TIMER_FREQ_HZ = 64'd1000000;
    localparam longint unsigned RPM_NUM       = 64'd6000 * TIMER_FREQ_HZ;

    localparam int RPM_BITS = $clog2(RPM_NUM + 64'd1);
    localparam int TGT_BITS = DATA_W + THR_W;
    localparam int NUM_W    = (RPM_BITS > TGT_BITS) ? RPM_BITS : TGT_BITS;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    localparam logic [DATA_W-1:0] PERIOD_FLOOR_RST = 32'd10000;
    localparam logic [THR_W-1:0]  THRESH_RST       = 7'd10;
    localparam logic [THR_W-1:0]  THRESH_MAX       = 7'd99;
    localparam logic [THR_W-1:0]  PCT_FULL         = 7'd100;
    localparam logic [DATA_W-1:0] TICKS_PER_MS     = 32'd1000;

    typedef enum logic [1:0] {
        REQ_CAPTURE = 2'd0,
        REQ_LATCH   = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_NOP     = 2'd3
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_FLOOR = 1'b0,
        CFG_THRESH       = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_BAND,
        S_CMP,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/rotation_speed_deviation_alarm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation speed deviation alarm core
// Measures rotation periods from timer captures, reports speed in hundredths
// of rpm and drives a buzzer level when the speed leaves a band around a
// latched target or when rotation events stop.
// ----------------------------------------------------------------------------
// Each transaction on the item channel (item_valid/item_ready) is a capture
// timestamp, a request to latch the last period as the target, a millisecond
// tick, or a no-op. Every item yields exactly one transaction on the result
// channel (result_valid/result_ready).
// One item is worked on at a time. The result of an accepted capture is loaded
// after the execute, divide, band and compare steps, that of a tick with a
// target set after the execute and divide steps, and that of any other item
// after the execute step alone. The next item can be accepted in the cycle
// after the result is loaded. The serial divider produces one quotient bit per
// cycle and is shared by the speed division and the timeout limit division.
// The result sits in an output register, so the next item is accepted while a
// result still waits; a stalled receiver only holds the sequencer in its
// final step. Reset clears the measurement state and the internal alarm level
// (not the output register) and loads the default minimum period and
// threshold. The configuration port may be used whenever the block is idle.
// ----------------------------------------------------------------------------
module rotation_speed_deviation_alarm_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rsda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsda_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [1:0]                     req_type,
    input  logic [rsda_pkg::DATA_W-1:0]    capture_value,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           alarm_on,
    output logic                           sample_valid,
    output logic [rsda_pkg::DATA_W-1:0]    period_value,
    output logic [rsda_pkg::RPM_W-1:0]     rpm_centi
);
    import rsda_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;

    logic [DATA_W-1:0] period_floor_reg;
    logic [THR_W-1:0]  thresh_reg;
    logic [DATA_W-1:0] last_capture_reg;
    logic [DATA_W-1:0] last_diff_reg;
    logic [DATA_W-1:0] target_reg;
    logic [DATA_W-1:0] idle_ticks_reg;
    logic              alarm_reg;
    logic              valid_reg;
    logic              result_valid_reg;

    req_kind_t         kind_reg;
    logic [DATA_W-1:0] cap_reg;
    logic [RPM_W-1:0]  rpm_reg;
    logic [PROD_W-1:0] prod_slow_reg;
    logic [PROD_W-1:0] prod_fast_reg;
    logic [PROD_W-1:0] t100_reg;
    logic              alarm_out_reg;
    logic              sample_out_reg;
    logic [DATA_W-1:0] period_out_reg;
    logic [RPM_W-1:0]  rpm_out_reg;

    logic [THR_W-1:0]  p_eff;
    logic [DATA_W-1:0] diff;
    logic              cap_ok;
    logic              tgt_set;
    logic              need_div;
    logic [PROD_W-1:0] t100;
    logic [NUM_W-1:0]  div_num;
    logic [DATA_W-1:0] div_den;
    logic              div_start;
    logic              out_load;
    div_stat_t         div_stat;
    logic [NUM_W-1:0]  quot;
    logic [RPM_W-1:0]  rpm_sat;

    rsda_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .stat      (div_stat),
        .quotient  (quot)
    );

    always_comb
    begin
        p_eff    = (thresh_reg > THRESH_MAX) ? THRESH_MAX : thresh_reg;
        diff     = cap_reg - last_capture_reg;
        cap_ok   = (diff != '0) && (diff >= period_floor_reg);
        tgt_set  = (target_reg != '0);
        need_div = ((kind_reg == REQ_CAPTURE) && cap_ok) || ((kind_reg == REQ_TICK) && tgt_set);
        t100     = PROD_W'(target_reg) * PROD_W'(PCT_FULL);
        rpm_sat  = (|quot[NUM_W-1:RPM_W]) ? {RPM_W{1'b1}} : quot[RPM_W-1:0];
        if (kind_reg == REQ_CAPTURE)
        begin
            div_num = NUM_W'(RPM_NUM);
            div_den = diff;
        end
        else
        begin
            div_num = NUM_W'(t100);
            div_den = DATA_W'(PCT_FULL - p_eff) * TICKS_PER_MS;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = need_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = (kind_reg == REQ_CAPTURE) ? S_BAND : S_DONE;
            end
            S_BAND:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == S_IDLE);
        div_start  = (state_reg == S_EXEC) && need_div;
        out_load   = (state_reg == S_DONE) && (!result_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            period_floor_reg <= PERIOD_FLOOR_RST;
            thresh_reg       <= THRESH_RST;
            last_capture_reg <= '0;
            last_diff_reg    <= '0;
            target_reg       <= '0;
            idle_ticks_reg   <= '0;
            alarm_reg        <= 1'b0;
            valid_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_PERIOD_FLOOR: period_floor_reg <= cfg_wdata;
                    CFG_THRESH:       thresh_reg       <= cfg_wdata[THR_W-1:0];
                    default:          period_floor_reg <= period_floor_reg;
                endcase
            end

            if (state_reg == S_EXEC)
            begin
                valid_reg <= (kind_reg == REQ_CAPTURE) && cap_ok;
                unique case (kind_reg)
                    REQ_CAPTURE:
                    begin
                        last_diff_reg  <= diff;
                        idle_ticks_reg <= '0;
                        if (cap_ok)
                            last_capture_reg <= cap_reg;
                    end
                    REQ_LATCH:
                    begin
                        target_reg     <= last_diff_reg;
                        idle_ticks_reg <= '0;
                    end
                    REQ_TICK:
                    begin
                        if (!tgt_set)
                            idle_ticks_reg <= '0;
                        else if (idle_ticks_reg != {DATA_W{1'b1}})
                            idle_ticks_reg <= idle_ticks_reg + 1'b1;
                    end
                    REQ_NOP:
                    begin
                        idle_ticks_reg <= idle_ticks_reg;
                    end
                    default:
                    begin
                        idle_ticks_reg <= idle_ticks_reg;
                    end
                endcase
            end

            if ((state_reg == S_DIV) && div_stat.done && (kind_reg == REQ_TICK))
            begin
                if (NUM_W'(idle_ticks_reg) >= quot)
                begin
                    alarm_reg      <= 1'b1;
                    idle_ticks_reg <= '0;
                end
            end

            if (state_reg == S_CMP)
                alarm_reg <= tgt_set && ((prod_slow_reg > t100_reg) || (prod_fast_reg < t100_reg));

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            kind_reg <= req_kind_t'(req_type);
            cap_reg  <= capture_value;
        end
        if ((state_reg == S_DIV) && div_stat.done && (kind_reg == REQ_CAPTURE))
            rpm_reg <= rpm_sat;
        if (state_reg == S_BAND)
        begin
            prod_slow_reg <= PROD_W'(last_diff_reg) * PROD_W'(PCT_FULL - p_eff);
            prod_fast_reg <= PROD_W'(last_diff_reg) * PROD_W'({1'b0, PCT_FULL} + {1'b0, p_eff});
            t100_reg      <= t100;
        end
        if (out_load)
        begin
            alarm_out_reg  <= alarm_reg;
            sample_out_reg <= valid_reg;
            period_out_reg <= last_diff_reg;
            rpm_out_reg    <= valid_reg ? rpm_reg : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign alarm_on     = alarm_out_reg;
    assign sample_valid = sample_out_reg;
    assign period_value = period_out_reg;
    assign rpm_centi    = rpm_out_reg;

endmodule

// ===== hdl/rsda_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle. Operands are captured on
// start; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module rsda_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rsda_pkg::NUM_W-1:0]  numerator,
    input  logic [rsda_pkg::DATA_W-1:0] divisor,
    output rsda_pkg::div_stat_t         stat,
    output logic [rsda_pkg::NUM_W-1:0]  quotient
);
    import rsda_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [NUM_W-1:0]  work_reg;
    logic [NUM_W-1:0]  work_next;
    logic [DATA_W-1:0] div_reg;
    logic [DATA_W-1:0] div_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff_trial;
    logic              fits;

    always_comb
    begin
        trial      = {rem_reg, work_reg[NUM_W-1]};
        fits       = trial >= {1'b0, div_reg};
        diff_trial = trial - {1'b0, div_reg};
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        work_next  = work_reg;
        div_next   = div_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            work_next = numerator;
            div_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = fits ? diff_trial[DATA_W-1:0] : trial[DATA_W-1:0];
            work_next = {work_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        div_reg  <= div_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

// ===== hdl/rsda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation speed deviation alarm port checker
// Watches the ports of the core over time and is bound to every instance.
// ----------------------------------------------------------------------------
module rsda_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic                        alarm_on,
    input logic                        sample_valid,
    input logic [rsda_pkg::DATA_W-1:0] period_value,
    input logic [rsda_pkg::RPM_W-1:0]  rpm_centi
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(alarm_on)
            && $stable(sample_valid) && $stable(period_value) && $stable(rpm_centi))
        else $error("Stalled result changed.");

    // Speed is reported only for accepted captures.
    a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !sample_valid |-> rpm_centi == '0)
        else $error("Speed reported without a valid sample.");

    // An accepted capture always has a nonzero period.
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sample_valid |-> period_value != '0)
        else $error("Valid sample with zero period.");

    // The core works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("New item accepted while busy.");

endmodule

bind rotation_speed_deviation_alarm_core rsda_checker u_rsda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .alarm_on     (alarm_on),
    .sample_valid (sample_valid),
    .period_value (period_value),
    .rpm_centi    (rpm_centi)
);

// ===== test/tb_rotation_speed_deviation_alarm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation speed deviation alarm core testbench
// Sends captures, target latches, millisecond ticks and no-ops through the
// item channel with random idle cycles and receiver stalls. Every result is
// checked against an in-bench prediction of speed, period and alarm level.
// The run steps through several minimum period and threshold settings,
// including the extremes, and writes them only while the core is idle.
// ----------------------------------------------------------------------------
module tb_rotation_speed_deviation_alarm_core;

    import rsda_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          STALL_LIMIT = 2000;
    localparam int          IDLE_PCT    = 13;
    localparam logic [63:0] SPEED_SCALE = 64'd6000 * 64'd1000000;
    localparam logic [63:0] RPM_CEIL    = 64'h1_FFFF_FFFF;

    typedef struct {
        req_kind_t         kind;
        logic [DATA_W-1:0] stamp;
    } rotation_item_t;

    typedef struct {
        logic              alarm;
        logic              sample;
        logic [DATA_W-1:0] period;
        logic [RPM_W-1:0]  rpm;
    } speed_report_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [DATA_W-1:0]    cfg_wdata     = '0;
    logic                 item_valid    = 1'b0;
    logic                 item_ready;
    logic [1:0]           req_type      = 2'b00;
    logic [DATA_W-1:0]    capture_value = '0;
    logic                 result_valid;
    logic                 result_ready  = 1'b0;
    logic                 alarm_on;
    logic                 sample_valid;
    logic [DATA_W-1:0]    period_value;
    logic [RPM_W-1:0]     rpm_centi;

    rotation_item_t pending_items[$];
    speed_report_t  expected_reports[$];

    logic [DATA_W-1:0] period_floor_cfg = PERIOD_FLOOR_RST;
    logic [THR_W-1:0]  thresh_cfg       = THRESH_RST;

    logic [DATA_W-1:0] ref_stamp   = '0;
    logic [DATA_W-1:0] ref_period  = '0;
    logic [DATA_W-1:0] target      = '0;
    logic [DATA_W-1:0] quiet_ticks = '0;
    logic              buzzer      = 1'b0;

    logic [DATA_W-1:0] next_stamp = '0;
    logic              no_idle    = 1'b0;
    int                error_count = 0;
    int                stall_cycles = 0;

    rotation_speed_deviation_alarm_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .capture_value(capture_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .alarm_on     (alarm_on),
        .sample_valid (sample_valid),
        .period_value (period_value),
        .rpm_centi    (rpm_centi)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic predict_report(input req_kind_t kind, input logic [DATA_W-1:0] stamp);
        speed_report_t     rep;
        logic [DATA_W-1:0] diff;
        logic [63:0]       pct;
        logic [63:0]       span;
        logic [63:0]       t100;
        logic [63:0]       limit;
        logic [63:0]       speed;
        rep  = '{alarm: 1'b0, sample: 1'b0, period: '0, rpm: '0};
        pct  = (thresh_cfg > THRESH_MAX) ? 64'(THRESH_MAX) : 64'(thresh_cfg);
        t100 = 64'(target) * 64'd100;
        case (kind)
            REQ_CAPTURE:
            begin
                diff        = stamp - ref_stamp;
                ref_period  = diff;
                quiet_ticks = '0;
                if (diff != 0 && diff >= period_floor_cfg)
                begin
                    span       = 64'(diff);
                    ref_stamp  = stamp;
                    rep.sample = 1'b1;
                    speed      = SPEED_SCALE / span;
                    if (speed > RPM_CEIL)
                        speed = RPM_CEIL;
                    rep.rpm = speed[RPM_W-1:0];
                    buzzer  = (target != 0) && (span * (64'd100 - pct) > t100 ||
                                                span * (64'd100 + pct) < t100);
                end
            end
            REQ_LATCH:
            begin
                target      = ref_period;
                quiet_ticks = '0;
            end
            REQ_TICK:
            begin
                if (target != 0)
                begin
                    limit = (t100 / (64'd100 - pct)) / 64'd1000;
                    if (quiet_ticks != '1)
                        quiet_ticks = quiet_ticks + 1'b1;
                    if (64'(quiet_ticks) >= limit)
                    begin
                        buzzer      = 1'b1;
                        quiet_ticks = '0;
                    end
                end
                else
                    quiet_ticks = '0;
            end
            default: ;
        endcase
        rep.alarm  = buzzer;
        rep.period = ref_period;
        expected_reports.push_back(rep);
    endtask

    // Item channel driver; the prediction is made at the edge that accepts the item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid    <= 1'b0;
            req_type      <= REQ_NOP;
            capture_value <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_report(req_kind_t'(req_type), capture_value);
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item_valid    <= 1'b1;
                    req_type      <= pending_items[0].kind;
                    capture_value <= pending_items[0].stamp;
                    void'(pending_items.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result channel monitor, receiver stalls and watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        speed_report_t exp_rep;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            if (result_valid && result_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    error_count++;
                    $error("result transaction with no expected result pending");
                end
                else
                begin
                    exp_rep = expected_reports.pop_front();
                    if (alarm_on !== exp_rep.alarm)
                    begin
                        error_count++;
                        $error("alarm_on expected %0d actual %0d", exp_rep.alarm, alarm_on);
                    end
                    if (sample_valid !== exp_rep.sample)
                    begin
                        error_count++;
                        $error("sample_valid expected %0d actual %0d",
                               exp_rep.sample, sample_valid);
                    end
                    if (period_value !== exp_rep.period)
                    begin
                        error_count++;
                        $error("period_value expected %0d actual %0d",
                               exp_rep.period, period_value);
                    end
                    if (rpm_centi !== exp_rep.rpm)
                    begin
                        error_count++;
                        $error("rpm_centi expected %0d actual %0d", exp_rep.rpm, rpm_centi);
                    end
                end
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic add_item(input req_kind_t kind, input logic [DATA_W-1:0] stamp);
        pending_items.push_back('{kind: kind, stamp: stamp});
    endtask

    task automatic add_capture(input logic [DATA_W-1:0] stamp);
        next_stamp = stamp;
        add_item(REQ_CAPTURE, stamp);
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || item_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PERIOD_FLOOR: period_floor_cfg = value;
            CFG_THRESH:       thresh_cfg       = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reconfigure(input logic [DATA_W-1:0] period_floor,
                               input logic [THR_W-1:0] pct);
        wait_for_drain();
        write_register(CFG_PERIOD_FLOOR, period_floor);
        write_register(CFG_THRESH, DATA_W'(pct));
        @(negedge clk);
    endtask

    // Captures spaced around a nominal period, mixed with bursts of ticks and
    // occasional target latches, plus some random captures and no-ops.
    task automatic queue_random_traffic(input int count, input logic [DATA_W-1:0] nominal);
        int                made;
        int                pick;
        int                burst;
        logic [DATA_W-1:0] jitter;
        logic [DATA_W-1:0] gap;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                gap = nominal;
                if ($urandom_range(0, 7) != 0)
                begin
                    jitter = $urandom_range(0, (nominal >> 2) + 1);
                    gap    = $urandom_range(0, 1) ? nominal + jitter : nominal - jitter;
                end
                add_capture(next_stamp + gap);
                made++;
            end
            else if (pick < 65)
            begin
                add_item(REQ_LATCH, $urandom);
                made++;
            end
            else if (pick < 92)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 300)
                                                    : $urandom_range(1, 25);
                repeat (burst) add_item(REQ_TICK, $urandom);
                made += burst;
            end
            else if (pick < 96)
            begin
                add_capture($urandom);
                made++;
            end
            else
            begin
                add_item(REQ_NOP, $urandom);
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_capture(32'd0);
        add_item(REQ_TICK, 32'd0);
        add_item(REQ_LATCH, 32'hFFFF_FFFF);
        add_capture(32'd9999);
        add_capture(32'd10000);
        add_item(REQ_LATCH, 32'd0);
        add_capture(32'd20000);
        add_capture(32'd31200);
        add_capture(32'd40200);
        add_capture(32'd50200);
        repeat (11) add_item(REQ_TICK, 32'h5555_AAAA);
        add_item(REQ_NOP, 32'hFFFF_FFFF);
        add_capture(32'hFFFF_FFFF);
        add_capture(32'd10000);
        add_capture(32'd10005);
        add_item(REQ_LATCH, 32'd0);
        add_item(REQ_TICK, 32'd0);

        reconfigure(32'd1, 7'd0);
        add_capture(next_stamp + 32'd1);
        add_capture(next_stamp + 32'd1);
        queue_random_traffic(350, $urandom_range(500, 30000));

        reconfigure(32'd500, 7'd99);
        queue_random_traffic(350, $urandom_range(500, 20000));

        reconfigure(32'd0, 7'd127);
        add_capture(next_stamp);
        queue_random_traffic(300, $urandom_range(50, 5000));

        reconfigure(32'hFFFF_FFFF, 7'd50);
        add_capture(next_stamp - 32'd1);
        queue_random_traffic(150, 32'hFFFF_FFFF);

        reconfigure(32'd2000, 7'd25);
        no_idle = 1'b1;
        queue_random_traffic(400, $urandom_range(2000, 15000));
        wait_for_drain();
        no_idle = 1'b0;

        reconfigure(PERIOD_FLOOR_RST, THRESH_RST);
        queue_random_traffic(350, $urandom_range(8000, 20000));

        while (pending_items.size() != 0 || item_valid)
            @(negedge clk);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (expected_reports.size() != 0)
        begin
            error_count++;
            $error("%0d expected results never arrived", expected_reports.size());
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
